// ===== src/pcc_pkg.sv =====
// shared constants, codes and control types of the clamped pid controller
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // integral accumulator and term width
    localparam int INT_W  = 64;
    localparam int LIMB_W = INT_W / 2;

    // shared multiplier operand width
    localparam int MUL_W  = (DATA_WIDTH + 1 > LIMB_W) ? DATA_WIDTH + 1 : LIMB_W;
    localparam int PROD_W = 2 * MUL_W;

    // exact product width before scaling, covers every term
    localparam int WIDE_W = DATA_WIDTH + INT_W + 1;

    // divider: dividend is |gain_d| * |error delta|
    localparam int DIV_N     = 2 * DATA_WIDTH + 1;
    localparam int DIV_CNT_W = $clog2(DIV_N);

    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER = CFG_IDX_W'(5);

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W - 1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_DIFF,
        OP_MUL_P,
        OP_MUL_I,
        OP_ACC,
        OP_MAG,
        OP_MUL_IL,
        OP_MUL_IH,
        OP_IV,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DV,
        OP_SUM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_in;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic dt_zero;
    } dp_status_t;

endpackage

// ===== src/pcc_ctrl.sv =====
// sequencer state machine of the clamped pid controller
`timescale 1ns / 1ps

module pcc_ctrl
    import pcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DISPATCH = 16'h0002,
        S_ERR      = 16'h0004,
        S_DIFF     = 16'h0008,
        S_MUL_P    = 16'h0010,
        S_MUL_I    = 16'h0020,
        S_ACC      = 16'h0040,
        S_MAG      = 16'h0080,
        S_MUL_IL   = 16'h0100,
        S_MUL_IH   = 16'h0200,
        S_IV       = 16'h0400,
        S_DIV_LOAD = 16'h0800,
        S_DIV      = 16'h1000,
        S_DV       = 16'h2000,
        S_SUM      = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        cmd.load_in  = 1'b0;
        cmd.load_out = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (status.kind || status.dt_zero) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                cmd.op     = OP_ERR;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = S_MUL_P;
            end
            S_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = S_MUL_I;
            end
            S_MUL_I: begin
                cmd.op     = OP_MUL_I;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = S_MAG;
            end
            S_MAG: begin
                cmd.op     = OP_MAG;
                state_next = S_MUL_IL;
            end
            S_MUL_IL: begin
                cmd.op     = OP_MUL_IL;
                state_next = S_MUL_IH;
            end
            S_MUL_IH: begin
                cmd.op     = OP_MUL_IH;
                state_next = S_IV;
            end
            S_IV: begin
                cmd.op     = OP_IV;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                cmd.op     = OP_DIV_LOAD;
                cnt_next   = DIV_CNT_W'(DIV_N - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DV;
                end
            end
            S_DV: begin
                cmd.op     = OP_DV;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.op     = OP_SUM;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/pcc_datapath.sv =====
// registers, shared multiplier, serial divider and clamp of the pid controller
`timescale 1ns / 1ps

module pcc_datapath
    import pcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    function automatic logic [INT_W-1:0] sat_add(input logic [INT_W-1:0] a,
                                                 input logic [INT_W-1:0] b);
        logic [INT_W-1:0] s;
        s = a + b;
        if ((a[INT_W-1] == b[INT_W-1]) && (s[INT_W-1] != a[INT_W-1])) begin
            s = a[INT_W-1] ? INT_MIN : INT_MAX;
        end
        return s;
    endfunction

    function automatic logic [INT_W-1:0] sat_mag(input logic neg,
                                                 input logic [WIDE_W-1:0] m);
        logic [INT_W-1:0] lo;
        lo = m[INT_W-1:0];
        if (|m[WIDE_W-1:INT_W-1]) begin
            return neg ? INT_MIN : INT_MAX;
        end
        return neg ? (~lo + 1'b1) : lo;
    endfunction

    // configuration
    logic [DATA_WIDTH-1:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DATA_WIDTH-1:0] out_lower_reg, out_upper_reg;

    // accepted item
    logic                  kind_reg;
    logic [DATA_WIDTH-1:0] meas_reg, dt_reg;

    // controller state
    logic [INT_W-1:0]      integ_reg;
    logic [DATA_WIDTH:0]   last_err_reg;

    // working registers
    logic [DATA_WIDTH:0]   err_reg;
    logic [DATA_WIDTH+1:0] de_reg;
    logic [PROD_W-1:0]     prod_reg, acc_reg;
    logic [INT_W-1:0]      imag_reg, p_reg, iv_reg, dv_reg, sum_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DIV_N-1:0]      quo_reg;

    // result register
    logic [DATA_WIDTH-1:0] drive_reg;
    logic                  limited_reg, step_err_reg;

    logic [DATA_WIDTH-1:0] gp_mag, gi_mag, gd_mag;
    logic [DATA_WIDTH:0]   err_mag, de_mag;
    logic [DATA_WIDTH+1:0] de_abs;
    logic [INT_W-1:0]      integ_mag;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [DATA_WIDTH:0]   err_next;
    logic [DATA_WIDTH+1:0] de_next;
    logic [WIDE_W-1:0]     iv_wide;
    logic [DATA_WIDTH:0]   rem_sh;
    logic                  div_ge;
    logic [INT_W-1:0]      upper_ext, lower_ext, clamp_val;
    logic                  clamp_hit;

    assign gp_mag    = gain_p_reg[DATA_WIDTH-1] ? (~gain_p_reg + 1'b1) : gain_p_reg;
    assign gi_mag    = gain_i_reg[DATA_WIDTH-1] ? (~gain_i_reg + 1'b1) : gain_i_reg;
    assign gd_mag    = gain_d_reg[DATA_WIDTH-1] ? (~gain_d_reg + 1'b1) : gain_d_reg;
    assign err_mag   = err_reg[DATA_WIDTH] ? (~err_reg + 1'b1) : err_reg;
    assign de_abs    = de_reg[DATA_WIDTH+1] ? (~de_reg + 1'b1) : de_reg;
    assign de_mag    = de_abs[DATA_WIDTH:0];
    assign integ_mag = integ_reg[INT_W-1] ? (~integ_reg + 1'b1) : integ_reg;

    assign err_next = {setpoint_reg[DATA_WIDTH-1], setpoint_reg}
                    - {meas_reg[DATA_WIDTH-1], meas_reg};
    assign de_next  = {err_reg[DATA_WIDTH], err_reg}
                    - {last_err_reg[DATA_WIDTH], last_err_reg};

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_P: begin
                mul_a = MUL_W'(gp_mag);
                mul_b = MUL_W'(err_mag);
            end
            OP_MUL_I: begin
                mul_a = MUL_W'(err_mag);
                mul_b = MUL_W'(dt_reg);
            end
            OP_MUL_IL: begin
                mul_a = MUL_W'(gi_mag);
                mul_b = MUL_W'(imag_reg[LIMB_W-1:0]);
            end
            OP_MUL_IH: begin
                mul_a = MUL_W'(gi_mag);
                mul_b = MUL_W'(imag_reg[INT_W-1:LIMB_W]);
            end
            OP_IV: begin
                mul_a = MUL_W'(gd_mag);
                mul_b = MUL_W'(de_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign iv_wide = WIDE_W'(acc_reg) + (WIDE_W'(prod_reg) << LIMB_W);

    // one restoring divider step
    assign rem_sh = {rem_reg, quo_reg[DIV_N-1]};
    assign div_ge = (rem_sh >= {1'b0, dt_reg});

    // clamp, upper limit first
    assign upper_ext = {{(INT_W - DATA_WIDTH){out_upper_reg[DATA_WIDTH-1]}}, out_upper_reg};
    assign lower_ext = {{(INT_W - DATA_WIDTH){out_lower_reg[DATA_WIDTH-1]}}, out_lower_reg};

    always_comb begin
        clamp_val = sum_reg;
        clamp_hit = 1'b0;
        if ($signed(sum_reg) > $signed(upper_ext)) begin
            clamp_val = upper_ext;
            clamp_hit = 1'b1;
        end else if ($signed(sum_reg) < $signed(lower_ext)) begin
            clamp_val = lower_ext;
            clamp_hit = 1'b1;
        end
    end

    // configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_lower_reg <= {1'b1, {(DATA_WIDTH - 1){1'b0}}};
            out_upper_reg <= {1'b0, {(DATA_WIDTH - 1){1'b1}}};
            integ_reg     <= '0;
            last_err_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SETPOINT:  setpoint_reg  <= cfg_data;
                    REG_GAIN_P:    gain_p_reg    <= cfg_data;
                    REG_GAIN_I:    gain_i_reg    <= cfg_data;
                    REG_GAIN_D:    gain_d_reg    <= cfg_data;
                    REG_OUT_LOWER: out_lower_reg <= cfg_data;
                    REG_OUT_UPPER: out_upper_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.op == OP_ACC) begin
                integ_reg <= sat_add(integ_reg,
                                     sat_mag(err_reg[DATA_WIDTH],
                                             WIDE_W'(prod_reg) >> FRAC_BITS));
            end
            if (cmd.load_out) begin
                if (kind_reg) begin
                    integ_reg    <= '0;
                    last_err_reg <= '0;
                end else if (dt_reg != '0) begin
                    last_err_reg <= err_reg;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= s_tuser;
            meas_reg <= s_tdata[DATA_WIDTH-1:0];
            dt_reg   <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
        case (cmd.op)
            OP_MUL_P, OP_MUL_I, OP_MUL_IL, OP_MUL_IH, OP_IV: begin
                prod_reg <= mul_a * mul_b;
            end
            default: begin
            end
        endcase
        case (cmd.op)
            OP_ERR: begin
                err_reg <= err_next;
            end
            OP_DIFF: begin
                de_reg <= de_next;
            end
            OP_MUL_I: begin
                p_reg <= sat_mag(gain_p_reg[DATA_WIDTH-1] ^ err_reg[DATA_WIDTH],
                                 WIDE_W'(prod_reg) >> FRAC_BITS);
            end
            OP_MAG: begin
                imag_reg <= integ_mag;
            end
            OP_MUL_IH: begin
                acc_reg <= prod_reg;
            end
            OP_IV: begin
                iv_reg <= sat_mag(gain_i_reg[DATA_WIDTH-1] ^ integ_reg[INT_W-1],
                                  iv_wide >> FRAC_BITS);
            end
            OP_DIV_LOAD: begin
                quo_reg <= prod_reg[DIV_N-1:0];
                rem_reg <= '0;
                sum_reg <= sat_add(p_reg, iv_reg);
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? DATA_WIDTH'(rem_sh - {1'b0, dt_reg})
                                  : DATA_WIDTH'(rem_sh);
                quo_reg <= {quo_reg[DIV_N-2:0], div_ge};
            end
            OP_DV: begin
                dv_reg <= sat_mag(gain_d_reg[DATA_WIDTH-1] ^ de_reg[DATA_WIDTH+1],
                                  WIDE_W'(quo_reg));
            end
            OP_SUM: begin
                sum_reg <= sat_add(sum_reg, dv_reg);
            end
            default: begin
            end
        endcase
        if (cmd.load_out) begin
            if (kind_reg) begin
                drive_reg    <= '0;
                limited_reg  <= 1'b0;
                step_err_reg <= 1'b0;
            end else if (dt_reg == '0) begin
                drive_reg    <= '0;
                limited_reg  <= 1'b0;
                step_err_reg <= 1'b1;
            end else begin
                drive_reg    <= clamp_val[DATA_WIDTH-1:0];
                limited_reg  <= clamp_hit;
                step_err_reg <= 1'b0;
            end
        end
    end

    assign status.kind    = kind_reg;
    assign status.dt_zero = (dt_reg == '0);

    assign m_tdata = M_TDATA_W'(drive_reg);
    assign m_tuser = {step_err_reg, limited_reg};

endmodule

// ===== src/pid_controller_clamped_core.sv =====
// top level of the clamped pid controller
//
//  channel  | direction | transfer carries
//  ---------+-----------+-----------------------------------------------
//  s_       | in        | one item: sample (measured, time_step) or clear
//  m_       | out       | one result per item: drive, limited, step_error
//  cfg_     | in        | register write: index, data
//
//  from transfer to m_tvalid a sample's time is set by the 2*DATA_WIDTH+1
//  steps of the one-bit-per-cycle divider for the derivative term and by the
//  single shared multiplier; clear and zero time step skip the arithmetic states;
//  s_tready returns in the same cycle that the result is posted
//  one item is in flight at a time; s_tready is high only when idle, and a
//  held result on m_ does not block the next input transfer, though the item
//  behind it waits in its last state until m_ is free
//  reset is synchronous, active low, and restores the register defaults
`timescale 1ns / 1ps

module pid_controller_clamped_core
    import pcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // measured, time_step
    input  logic                  s_tuser,   // kind

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // drive
    output logic [M_TUSER_W-1:0]  m_tuser,   // limited, step_error

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    a_busy_after_accept : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input accepted while an item is in flight");

    a_result_slot_free : assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready)
    ) else $error("result overwritten before transfer");

    a_flags_exclusive : assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1])
    ) else $error("limited and step_error both set");

    a_step_error_zero : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0)
    ) else $error("step error with nonzero drive");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the clamped pid controller core
`timescale 1ns / 1ps

module tb_top;
    import pcc_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_PAD   = 100;
    localparam int PHASE_ITEMS = 125;
    localparam int RAND_PHASES = 6;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    typedef struct packed {
        logic                  kind;
        logic [DATA_WIDTH-1:0] measured;
        logic [DATA_WIDTH-1:0] time_step;
    } pid_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] drive;
        logic                  limited;
        logic                  step_error;
    } pid_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_WIDTH-1:0] cfg_data = '0;

    pid_item_t   pending_samples[$];
    pid_result_t expected_results[$];
    pid_item_t   cur_item;

    logic [DATA_WIDTH-1:0] ctl_reg [0:5];
    logic signed [63:0]    integ_acc = '0;
    logic signed [63:0]    prev_err = '0;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  hold_left = 0;
    bit  hold_toggle = 1'b0;
    bit  hold_seen = 1'b0;

    pid_controller_clamped_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [63:0] widen(logic [DATA_WIDTH-1:0] v);
        return {{(64 - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] sat_mag(logic neg, logic [127:0] m);
        if (m >= 128'h8000_0000_0000_0000) begin
            return neg ? INT_MIN : INT_MAX;
        end
        return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    // product scaled down by the fraction bits, truncated toward zero
    function automatic logic signed [63:0] scale_mul(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic [127:0] prod;
        prod = {64'b0, abs64(a)} * {64'b0, abs64(b)};
        return sat_mag(a[63] ^ b[63], prod >> FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] ratio_mul(logic signed [63:0] a,
                                                     logic signed [63:0] b,
                                                     logic [63:0] d);
        logic [127:0] prod;
        prod = {64'b0, abs64(a)} * {64'b0, abs64(b)};
        return sat_mag(a[63] ^ b[63], prod / {64'b0, d});
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? INT_MIN : INT_MAX;
        end
        return s[63:0];
    endfunction

    function automatic pid_result_t compute_drive(pid_item_t it);
        pid_result_t        r;
        logic signed [63:0] err;
        logic signed [63:0] p_term;
        logic signed [63:0] i_term;
        logic signed [63:0] d_term;
        logic signed [63:0] total;
        r = '0;
        if (it.kind == KIND_CLEAR) begin
            integ_acc = '0;
            prev_err  = '0;
            return r;
        end
        if (it.time_step == '0) begin
            r.step_error = 1'b1;
            return r;
        end
        err       = widen(ctl_reg[REG_SETPOINT]) - widen(it.measured);
        p_term    = scale_mul(widen(ctl_reg[REG_GAIN_P]), err);
        integ_acc = sat_add(integ_acc, scale_mul(err, {32'b0, it.time_step}));
        i_term    = scale_mul(widen(ctl_reg[REG_GAIN_I]), integ_acc);
        d_term    = ratio_mul(widen(ctl_reg[REG_GAIN_D]), err - prev_err,
                              {32'b0, it.time_step});
        total     = sat_add(sat_add(p_term, i_term), d_term);
        // upper limit is tested first, so an inverted pair favours it
        if (total > widen(ctl_reg[REG_OUT_UPPER])) begin
            total     = widen(ctl_reg[REG_OUT_UPPER]);
            r.limited = 1'b1;
        end else if (total < widen(ctl_reg[REG_OUT_LOWER])) begin
            total     = widen(ctl_reg[REG_OUT_LOWER]);
            r.limited = 1'b1;
        end
        prev_err = err;
        r.drive  = total[DATA_WIDTH-1:0];
        return r;
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] spread(int unsigned span);
        return DATA_WIDTH'($urandom_range(0, 2 * span)) - DATA_WIDTH'(span);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return spread(32'h0002_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_item(logic kind, logic [DATA_WIDTH-1:0] meas,
                                      logic [DATA_WIDTH-1:0] dt);
        pid_item_t it;
        it.kind      = kind;
        it.measured  = meas;
        it.time_step = dt;
        pending_samples.push_back(it);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= REG_OUT_UPPER) begin
            ctl_reg[idx] = val;
        end
        @(negedge aclk);
    endtask

    // wait until every offered item has been answered, then let the core settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input pid_result_t want,
                                 input pid_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected drive %h limited %b step_error %b, got drive %h limited %b step_error %b",
                     what, want.drive, want.limited, want.step_error,
                     got.drive, got.limited, got.step_error);
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(compute_drive(cur_item));
                tx_wait = draw_wait(tx_calm);
                if ($urandom_range(0, 39) == 0) begin
                    tx_calm = !tx_calm;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    cur_item = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_item.time_step, cur_item.measured});
                    s_tuser  <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        pid_result_t got;
        pid_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.drive      = m_tdata[DATA_WIDTH-1:0];
                got.limited    = m_tuser[0];
                got.step_error = m_tuser[1];
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected transfer", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.drive !== want.drive || got.limited !== want.limited ||
                        got.step_error !== want.step_error) begin
                        note_mismatch("wrong field", want, got);
                    end
                end
                rx_wait = draw_wait(rx_calm);
                if ($urandom_range(0, 39) == 0) begin
                    rx_calm = !rx_calm;
                end
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [DATA_WIDTH-1:0] sp;
        logic [DATA_WIDTH-1:0] lo;
        logic [DATA_WIDTH-1:0] hi;
        logic [DATA_WIDTH-1:0] dt;
        logic                  kind;
        ctl_reg[REG_SETPOINT]  = '0;
        ctl_reg[REG_GAIN_P]    = '0;
        ctl_reg[REG_GAIN_I]    = '0;
        ctl_reg[REG_GAIN_D]    = '0;
        ctl_reg[REG_OUT_LOWER] = 32'h8000_0000;
        ctl_reg[REG_OUT_UPPER] = 32'h7fff_ffff;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults
        push_item(KIND_SAMPLE, 32'h1234_5678, 32'h0001_0000);
        push_item(KIND_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // moderate gains, narrow limits
        write_reg(REG_SETPOINT,  32'h0001_0000);
        write_reg(REG_GAIN_P,    32'h0001_0000);
        write_reg(REG_GAIN_I,    32'h0000_4000);
        write_reg(REG_GAIN_D,    32'h0000_8000);
        write_reg(REG_OUT_LOWER, 32'hfff0_0000);
        write_reg(REG_OUT_UPPER, 32'h0010_0000);
        write_reg(REG_SPARE_LO,  32'hdead_beef);
        write_reg(REG_SPARE_HI,  32'h8000_0001);
        push_item(KIND_SAMPLE, 32'h0000_0000, 32'h0001_0000);
        push_item(KIND_SAMPLE, 32'h7fff_ffff, 32'h0000_0001);
        push_item(KIND_SAMPLE, 32'h8000_0000, 32'hffff_ffff);
        push_item(KIND_CLEAR,  32'h5a5a_a5a5, 32'h1234_0000);
        push_item(KIND_CLEAR,  32'hffff_ffff, 32'h0000_0000);
        push_item(KIND_SAMPLE, 32'h0001_0000, 32'h0001_0000);
        push_item(KIND_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        push_item(KIND_SAMPLE, 32'hffff_0000, 32'h0000_8000);
        wait_drained();

        // extreme gains, lower limit above upper limit
        write_reg(REG_SETPOINT,  32'h8000_0000);
        write_reg(REG_GAIN_P,    32'h7fff_ffff);
        write_reg(REG_GAIN_I,    32'h8000_0000);
        write_reg(REG_GAIN_D,    32'h7fff_ffff);
        write_reg(REG_OUT_LOWER, 32'h0000_1000);
        write_reg(REG_OUT_UPPER, 32'hffff_f000);
        push_item(KIND_SAMPLE, 32'h7fff_ffff, 32'hffff_ffff);
        push_item(KIND_SAMPLE, 32'h7fff_ffff, 32'h0000_0001);
        push_item(KIND_SAMPLE, 32'h0000_0000, 32'h0000_0001);
        push_item(KIND_SAMPLE, 32'h8000_0000, 32'h0001_0000);
        push_item(KIND_SAMPLE, 32'h8000_0001, 32'h0001_0000);
        wait_drained();

        // opposite extremes, full output range
        write_reg(REG_SETPOINT,  32'h7fff_ffff);
        write_reg(REG_GAIN_P,    32'h8000_0000);
        write_reg(REG_GAIN_I,    32'h7fff_ffff);
        write_reg(REG_GAIN_D,    32'h8000_0000);
        write_reg(REG_OUT_LOWER, 32'h8000_0000);
        write_reg(REG_OUT_UPPER, 32'h7fff_ffff);
        push_item(KIND_SAMPLE, 32'h8000_0000, 32'hffff_ffff);
        push_item(KIND_SAMPLE, 32'h8000_0000, 32'h0000_0001);
        push_item(KIND_SAMPLE, 32'h7fff_ffff, 32'h0001_0000);
        push_item(KIND_CLEAR,  32'h8000_0000, 32'hffff_ffff);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            sp = rand_word();
            write_reg(REG_SETPOINT, sp);
            write_reg(REG_GAIN_P, ($urandom_range(0, 7) == 0) ? rand_word()
                                                              : spread(32'h0004_0000));
            write_reg(REG_GAIN_I, ($urandom_range(0, 7) == 0) ? rand_word()
                                                              : spread(32'h0001_0000));
            write_reg(REG_GAIN_D, ($urandom_range(0, 7) == 0) ? rand_word()
                                                              : spread(32'h0004_0000));
            case ($urandom_range(0, 3))
                0: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7fff_ffff;
                end
                1: begin
                    lo = $urandom();
                    hi = $urandom();
                end
                default: begin
                    lo = -DATA_WIDTH'($urandom_range(0, 32'h0040_0000));
                    hi = DATA_WIDTH'($urandom_range(0, 32'h0040_0000));
                end
            endcase
            write_reg(REG_OUT_LOWER, lo);
            write_reg(REG_OUT_UPPER, hi);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = ($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_SAMPLE;
                case ($urandom_range(0, 19))
                    0: dt = '0;
                    1, 2, 3, 4, 5, 6, 7, 8: dt = $urandom_range(1, 32'h0004_0000);
                    9, 10, 11, 12, 13, 14: dt = $urandom_range(1, 255);
                    default: dt = $urandom();
                endcase
                push_item(kind, ($urandom_range(0, 3) == 0) ? rand_word()
                                                            : sp - spread(32'h0008_0000),
                          dt);
            end
            if (ph == 1 || ph == 4) begin
                @(posedge aclk);
                hold_toggle <= ~hold_toggle;
            end
        end

        wait_drained();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
